[src/irc_line_tokenizer_assert.svh]
// Assertion macros shared by the line tokenizer modules.
`ifndef IRC_LINE_TOKENIZER_ASSERT_SVH
`define IRC_LINE_TOKENIZER_ASSERT_SVH

// Same-cycle implication, clocked on clk and disabled while rst_n is low.
`define IRC_LT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("irc_lt: assertion failed");

// Next-cycle implication, clocked on clk and disabled while rst_n is low.
`define IRC_LT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("irc_lt: assertion failed");

`endif

[src/irc_lt_pkg.sv]
// Types and constants shared by the line tokenizer modules.
`default_nettype none
package irc_lt_pkg;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int RESULT_DEPTH = 4;

    typedef enum logic [2:0] {
        K_PREFIX  = 3'd0,
        K_CMDBYTE = 3'd1,
        K_NUMERIC = 3'd2,
        K_PARAM   = 3'd3,
        K_BADNUM  = 3'd4,
        K_END     = 3'd5
    } kind_t;

    typedef struct packed {
        kind_t       field_kind;
        logic [7:0]  out_byte;
        logic [9:0]  command_number;
        logic        run_last;
    } result_t;

    // Up to two results produced by one byte, packed toward r0.
    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t r0;
        result_t r1;
    } push_t;

endpackage
`default_nettype wire

[src/irc_lt_if.sv]
// Request channel interfaces for the byte input and the result output.
`default_nettype none
interface irc_lt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface irc_lt_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] field_kind;
    logic [7:0] out_byte;
    logic [9:0] command_number;
    logic       run_last;

    modport source (output valid, output field_kind, output out_byte,
                    output command_number, output run_last, input ready);
    modport sink (input valid, input field_kind, input out_byte,
                  input command_number, input run_last, output ready);
endinterface
`default_nettype wire

[src/irc_lt_step.sv]
// Message phase tracker: turns one registered byte into zero, one or two results.
`default_nettype none
`include "irc_line_tokenizer_assert.svh"
module irc_lt_step (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            fire,
    input  wire logic [7:0]      data,
    output irc_lt_pkg::push_t    push
);

    typedef enum logic [2:0] {
        PH_LINE   = 3'd0,
        PH_PREFIX = 3'd1,
        PH_CMD    = 3'd2,
        PH_NUM    = 3'd3,
        PH_NSKIP  = 3'd4,
        PH_TEXT   = 3'd5,
        PH_PARAMS = 3'd6
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [1:0]  dcount;
        logic [9:0]  accum;
        logic        bad;
    } st_t;

    typedef struct packed {
        st_t                  st;
        logic                 hit;
        irc_lt_pkg::result_t  res;
    } feed_t;

    // One byte through the phase logic; at most one result.
    function automatic feed_t feed(st_t s, logic [7:0] b);
        feed_t      f;
        logic       dig;
        logic       start;
        logic [7:0] diff;
        logic [9:0] acc;
        logic       bad;
        logic [1:0] dc;
        f     = '{st: s, hit: 1'b0, res: '0};
        dig   = (b >= irc_lt_pkg::CH_ZERO) && (b <= irc_lt_pkg::CH_NINE);
        diff  = b - irc_lt_pkg::CH_ZERO;
        start = 1'b0;
        acc   = {s.accum[6:0], 3'b000} + {s.accum[8:0], 1'b0} + {6'd0, diff[3:0]};
        bad   = s.bad | ~dig;
        dc    = s.dcount + 2'd1;
        case (s.phase)
            PH_PREFIX:
            begin
                if (b == irc_lt_pkg::CH_SPACE)
                begin
                    f.st.phase = PH_CMD;
                end
                else
                begin
                    f.hit = 1'b1;
                    f.res.field_kind = irc_lt_pkg::K_PREFIX;
                    f.res.out_byte = b;
                end
            end
            PH_CMD:
            begin
                start = 1'b1;
            end
            PH_NUM:
            begin
                if (dc == 2'd3)
                begin
                    f.st.phase  = PH_NSKIP;
                    f.st.dcount = 2'd0;
                    f.st.accum  = 10'd0;
                    f.st.bad    = 1'b0;
                    f.hit       = 1'b1;
                    if (bad)
                    begin
                        f.res.field_kind = irc_lt_pkg::K_BADNUM;
                    end
                    else
                    begin
                        f.res.field_kind = irc_lt_pkg::K_NUMERIC;
                        f.res.command_number = dig ? acc : s.accum;
                    end
                end
                else
                begin
                    f.st.dcount = dc;
                    f.st.accum  = dig ? acc : s.accum;
                    f.st.bad    = bad;
                end
            end
            PH_NSKIP:
            begin
                f.st.phase = PH_PARAMS;
            end
            PH_TEXT:
            begin
                if (b == irc_lt_pkg::CH_SPACE)
                begin
                    f.st.phase = PH_PARAMS;
                end
                else
                begin
                    f.hit = 1'b1;
                    f.res.field_kind = irc_lt_pkg::K_CMDBYTE;
                    f.res.out_byte = b;
                end
            end
            PH_PARAMS:
            begin
                f.hit = 1'b1;
                f.res.field_kind = irc_lt_pkg::K_PARAM;
                f.res.out_byte = b;
            end
            default:
            begin
                if (b == irc_lt_pkg::CH_COLON)
                begin
                    f.st.phase = PH_PREFIX;
                end
                else
                begin
                    start = 1'b1;
                end
            end
        endcase
        // Command start, also reached from line start without a colon.
        if (start)
        begin
            if (dig)
            begin
                f.st.phase  = PH_NUM;
                f.st.dcount = 2'd1;
                f.st.accum  = {6'd0, diff[3:0]};
                f.st.bad    = 1'b0;
            end
            else if (b == irc_lt_pkg::CH_SPACE)
            begin
                f.st.phase = PH_PARAMS;
            end
            else
            begin
                f.st.phase = PH_TEXT;
                f.hit = 1'b1;
                f.res.field_kind = irc_lt_pkg::K_CMDBYTE;
                f.res.out_byte = b;
            end
        end
        return f;
    endfunction

    st_t   st_reg;
    st_t   st_next;
    logic  cr_reg;
    logic  cr_next;
    feed_t held_f;
    feed_t byte_f;
    st_t   mid_st;
    logic  hit_a;
    logic  hit_b;
    irc_lt_pkg::result_t res_end;

    always_comb
    begin
        res_end = '0;
        res_end.field_kind = irc_lt_pkg::K_END;
        res_end.run_last = 1'b1;
        held_f  = feed(st_reg, irc_lt_pkg::CH_CR);
        mid_st  = cr_reg ? held_f.st : st_reg;
        hit_a   = cr_reg & held_f.hit;
        byte_f  = feed(mid_st, data);
        hit_b   = (data != irc_lt_pkg::CH_CR) & byte_f.hit;
        st_next = (data == irc_lt_pkg::CH_CR) ? mid_st : byte_f.st;
        cr_next = (data == irc_lt_pkg::CH_CR);
        push.v0 = fire & (hit_a | hit_b);
        push.v1 = fire & hit_a & hit_b;
        push.r0 = hit_a ? held_f.res : byte_f.res;
        push.r0.run_last = ~(hit_a & hit_b);
        push.r1 = byte_f.res;
        push.r1.run_last = 1'b1;
        // CR LF ends the message in any phase.
        if (cr_reg && (data == irc_lt_pkg::CH_LF))
        begin
            st_next = '{phase: PH_LINE, dcount: 2'd0, accum: 10'd0, bad: 1'b0};
            cr_next = 1'b0;
            push.v0 = fire;
            push.v1 = 1'b0;
            push.r0 = res_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '{phase: PH_LINE, dcount: 2'd0, accum: 10'd0, bad: 1'b0};
            cr_reg <= 1'b0;
        end
        else if (fire)
        begin
            st_reg <= st_next;
            cr_reg <= cr_next;
        end
    end

    `IRC_LT_ASSERT_NXT(a_end_to_line, push.v0 && (push.r0.field_kind == irc_lt_pkg::K_END), st_reg.phase == PH_LINE)
    `IRC_LT_ASSERT_IMP(a_num_range, push.v0 && (push.r0.field_kind == irc_lt_pkg::K_NUMERIC), push.r0.command_number <= 10'd999)
    `IRC_LT_ASSERT_IMP(a_dcount_range, 1'b1, st_reg.dcount != 2'd3)

endmodule
`default_nettype wire

[src/irc_lt_fifo.sv]
// Result queue: takes up to two results a cycle, hands out one per request.
`default_nettype none
`include "irc_line_tokenizer_assert.svh"
module irc_lt_fifo #(
    parameter int DEPTH = irc_lt_pkg::RESULT_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire irc_lt_pkg::push_t push,
    output logic                  room,
    irc_lt_out_if.source          out_ch
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    function automatic logic [PW-1:0] wrap_inc(logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    irc_lt_pkg::result_t slots_reg [DEPTH];
    logic [PW-1:0] wr_reg;
    logic [PW-1:0] wr_next;
    logic [PW-1:0] rd_reg;
    logic [PW-1:0] rd_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [PW-1:0] wr_1;
    logic [PW-1:0] wr_2;
    logic          pop;
    irc_lt_pkg::result_t head;

    always_comb
    begin
        pop        = out_ch.valid & out_ch.ready;
        wr_1       = wrap_inc(wr_reg);
        wr_2       = wrap_inc(wr_1);
        wr_next    = push.v1 ? wr_2 : (push.v0 ? wr_1 : wr_reg);
        rd_next    = pop ? wrap_inc(rd_reg) : rd_reg;
        count_next = count_reg + CW'(push.v0) + CW'(push.v1) - CW'(pop);
        // Room for a byte's worst case of two results.
        room       = count_reg <= CW'(DEPTH - 2);
        head       = slots_reg[rd_reg];
    end

    assign out_ch.valid          = (count_reg != '0);
    assign out_ch.field_kind     = head.field_kind;
    assign out_ch.out_byte       = head.out_byte;
    assign out_ch.command_number = head.command_number;
    assign out_ch.run_last       = head.run_last;

    always_ff @(posedge clk)
    begin
        if (push.v0)
        begin
            slots_reg[wr_reg] <= push.r0;
        end
        if (push.v1)
        begin
            slots_reg[wr_1] <= push.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    `IRC_LT_ASSERT_IMP(a_no_overflow, push.v0, count_reg <= CW'(DEPTH - 2))
    `IRC_LT_ASSERT_IMP(a_packed_push, push.v1, push.v0)
    `IRC_LT_ASSERT_IMP(a_empty_ptrs, count_reg == '0, rd_reg == wr_reg)

endmodule
`default_nettype wire

[src/irc_line_tokenizer.sv]
// Top level of the chat-protocol line tokenizer.
//
//   Channel   Direction  Payload
//   in_ch     sink       in_byte
//   out_ch    source     field_kind, out_byte, command_number, run_last
//
// One byte is accepted per cycle while the result queue has room; a byte that
// yields two results writes both to the queue together, and they leave it as two transfers.
// An accepted byte waits in the input register until the result queue has room for it.
// The input register stalls while the four-entry result queue has fewer than two
// free entries.
// Reset is asynchronous and returns the tokenizer to the start of a line.
`default_nettype none
module irc_line_tokenizer #(
    parameter int DEPTH = irc_lt_pkg::RESULT_DEPTH
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    irc_lt_in_if.sink     in_ch,
    irc_lt_out_if.source  out_ch
);

    logic              byte_valid_reg;
    logic [7:0]        byte_reg;
    logic              room;
    logic              fire;
    irc_lt_pkg::push_t push;

    assign fire        = byte_valid_reg & room;
    assign in_ch.ready = ~byte_valid_reg | fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
        end
        else if (in_ch.valid && in_ch.ready)
        begin
            byte_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            byte_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            byte_reg <= in_ch.in_byte;
        end
    end

    irc_lt_step u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .data  (byte_reg),
        .push  (push)
    );

    irc_lt_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .room   (room),
        .out_ch (out_ch)
    );

endmodule
`default_nettype wire

[test/irc_lt_token_check.sv]
`timescale 1ns / 1ps
// Token checker for the line tokenizer: watches both channels, predicts tokens and compares them.
module irc_lt_token_check (
    input  logic  clk,
    input  logic  rst_n,
    irc_lt_in_if  in_mon,
    irc_lt_out_if out_mon,
    output int    mismatches,
    output int    outstanding,
    output int    checked
);
    import irc_lt_pkg::*;

    typedef enum logic [2:0] {
        PH_LINE   = 3'd0,
        PH_PREFIX = 3'd1,
        PH_CMD    = 3'd2,
        PH_NUM    = 3'd3,
        PH_NSKIP  = 3'd4,
        PH_TEXT   = 3'd5,
        PH_PARAMS = 3'd6
    } phase_t;

    phase_t     phase;
    logic [1:0] digit_count;
    logic [9:0] number_accum;
    logic       cr_held;
    logic       numeric_bad;
    result_t    token_q[$];
    int         err_count;
    int         match_count;

    function automatic result_t make_token(kind_t k, logic [7:0] b, logic [9:0] num);
        result_t r;
        r.field_kind     = k;
        r.out_byte       = b;
        r.command_number = num;
        r.run_last       = 1'b0;
        return r;
    endfunction

    function automatic bit is_digit(logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function automatic void clear_numeric();
        digit_count  = 2'd0;
        number_accum = 10'd0;
        numeric_bad  = 1'b0;
    endfunction

    // Runs one byte through the phase logic; returns 1 when it yields a token.
    function automatic bit tokenize_byte(input logic [7:0] b, output result_t r);
        logic [9:0] value;
        bit         bad;
        r = make_token(K_PREFIX, 8'h00, 10'd0);
        case (phase)
            PH_PREFIX:
            begin
                if (b == CH_SPACE)
                begin
                    phase = PH_CMD;
                    return 0;
                end
                r = make_token(K_PREFIX, b, 10'd0);
                return 1;
            end
            PH_CMD: ;
            PH_NUM:
            begin
                if (is_digit(b))
                    number_accum = 10'(number_accum * 10 + (b - CH_ZERO));
                else
                    numeric_bad = 1'b1;
                digit_count = digit_count + 2'd1;
                if (digit_count == 2'd3)
                begin
                    value = number_accum;
                    bad   = numeric_bad;
                    clear_numeric();
                    phase = PH_NSKIP;
                    r = bad ? make_token(K_BADNUM, 8'h00, 10'd0)
                            : make_token(K_NUMERIC, 8'h00, value);
                    return 1;
                end
                return 0;
            end
            PH_NSKIP:
            begin
                phase = PH_PARAMS;
                return 0;
            end
            PH_TEXT:
            begin
                if (b == CH_SPACE)
                begin
                    phase = PH_PARAMS;
                    return 0;
                end
                r = make_token(K_CMDBYTE, b, 10'd0);
                return 1;
            end
            PH_PARAMS:
            begin
                r = make_token(K_PARAM, b, 10'd0);
                return 1;
            end
            default:
            begin
                if (b == CH_COLON)
                begin
                    phase = PH_PREFIX;
                    return 0;
                end
            end
        endcase
        // Start of the command, reached from line start without a colon as well.
        if (is_digit(b))
        begin
            phase        = PH_NUM;
            digit_count  = 2'd1;
            number_accum = 10'(b - CH_ZERO);
            numeric_bad  = 1'b0;
            return 0;
        end
        if (b == CH_SPACE)
        begin
            phase = PH_PARAMS;
            return 0;
        end
        phase = PH_TEXT;
        r = make_token(K_CMDBYTE, b, 10'd0);
        return 1;
    endfunction

    // A CR is held back one byte so that CR LF can be recognized as the message end.
    function automatic void predict_tokens(input logic [7:0] b);
        result_t r;
        result_t step_q[$];
        if (cr_held)
        begin
            cr_held = 1'b0;
            if (b == CH_LF)
            begin
                r = make_token(K_END, 8'h00, 10'd0);
                r.run_last = 1'b1;
                token_q.push_back(r);
                phase = PH_LINE;
                clear_numeric();
                return;
            end
            if (tokenize_byte(CH_CR, r))
                step_q.push_back(r);
        end
        if (b == CH_CR)
            cr_held = 1'b1;
        else if (tokenize_byte(b, r))
            step_q.push_back(r);
        if (step_q.size() > 0)
            step_q[step_q.size() - 1].run_last = 1'b1;
        foreach (step_q[i])
            token_q.push_back(step_q[i]);
    endfunction

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            err_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t seen;
        result_t want;
        if (!rst_n)
        begin
            phase   = PH_LINE;
            cr_held = 1'b0;
            clear_numeric();
            token_q.delete();
            err_count   = 0;
            match_count = 0;
        end
        else
        begin
            if (in_mon.valid && in_mon.ready)
                predict_tokens(in_mon.in_byte);
            if (out_mon.valid && out_mon.ready)
            begin
                seen.field_kind     = kind_t'(out_mon.field_kind);
                seen.out_byte       = out_mon.out_byte;
                seen.command_number = out_mon.command_number;
                seen.run_last       = out_mon.run_last;
                if (token_q.size() == 0)
                begin
                    err_count++;
                    $display("%0t: unexpected token, expected none, got kind %0d byte %02h num %0d last %0b",
                             $time, seen.field_kind, seen.out_byte, seen.command_number,
                             seen.run_last);
                end
                else
                begin
                    want = token_q.pop_front();
                    match_count++;
                    compare_field("field_kind", int'(want.field_kind), int'(seen.field_kind));
                    compare_field("out_byte", int'(want.out_byte), int'(seen.out_byte));
                    compare_field("command_number", int'(want.command_number),
                                  int'(seen.command_number));
                    compare_field("run_last", int'(want.run_last), int'(seen.run_last));
                end
            end
        end
        mismatches  <= err_count;
        outstanding <= token_q.size();
        checked     <= match_count;
    end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// Testbench top for the line tokenizer: byte stimulus, idling phases and the verdict.
module tb;
    import irc_lt_pkg::*;

    localparam int ITEM_TARGET = 550;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 8;
    localparam int HOLD_CYCLES = 300;

    logic clk;
    logic rst_n;
    logic long_hold = 1'b0;
    int   idle_pct = 0;
    int   stall_pct = 0;
    int   bytes_sent = 0;
    int   cycle_count = 0;
    int   mismatches;
    int   outstanding;
    int   checked;

    irc_lt_in_if  in_ch();
    irc_lt_out_if out_ch();

    irc_line_tokenizer uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    irc_lt_token_check token_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_mon      (in_ch),
        .out_mon     (out_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .checked     (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[irc_line_tokenizer] ERROR");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off counted here.
    initial
    begin
        int held;
        held = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold && held < HOLD_CYCLES)
            begin
                out_ch.ready <= 1'b0;
                held++;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic logic [7:0] random_byte();
        logic [7:0] special [6];
        special = '{CH_COLON, CH_SPACE, CH_CR, CH_LF, CH_ZERO, CH_NINE};
        if ($urandom_range(3) == 0)
            return special[$urandom_range(5)];
        return 8'($urandom_range(255));
    endfunction

    // A byte that neither ends a field nor starts a line end.
    function automatic logic [7:0] field_byte();
        logic [7:0] b;
        do
            b = random_byte();
        while (b == CH_SPACE || b == CH_CR);
        return b;
    endfunction

    // Valid stays high from one request to the next unless the sender idles.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // Mostly well-formed messages with random content; some lack the line end.
    task automatic send_message();
        logic [7:0] b;
        if ($urandom_range(1))
        begin
            send_byte(CH_COLON);
            repeat ($urandom_range(4)) send_byte(field_byte());
            send_byte(CH_SPACE);
        end
        if ($urandom_range(1))
        begin
            repeat (3) send_byte($urandom_range(9) == 0 ? random_byte()
                                                        : 8'(CH_ZERO + $urandom_range(9)));
            send_byte(CH_SPACE);
        end
        else
        begin
            do
                b = field_byte();
            while (b == CH_COLON || (b >= CH_ZERO && b <= CH_NINE));
            send_byte(b);
            repeat ($urandom_range(4)) send_byte(field_byte());
            send_byte(CH_SPACE);
        end
        repeat ($urandom_range(8)) send_byte(random_byte());
        if ($urandom_range(9) != 0)
        begin
            send_byte(CH_CR);
            send_byte(CH_LF);
        end
    endtask

    task automatic run_phase(input int idle, input int stall, input int upto);
        idle_pct  = idle;
        stall_pct = stall;
        while (bytes_sent < upto)
        begin
            if ($urandom_range(4) == 0)
                repeat ($urandom_range(1, 10)) send_byte(random_byte());
            else
                send_message();
        end
        drain();
    endtask

    initial
    begin
        logic [7:0] opening[$];
        opening = '{
            CH_COLON, 8'hFF, CH_SPACE, CH_NINE, CH_NINE, CH_NINE, CH_SPACE, 8'h00, CH_CR, CH_LF,
            CH_COLON, CH_SPACE, 8'h31, CH_CR, 8'h35, CH_SPACE, CH_LF, CH_CR, CH_LF,
            CH_SPACE, 8'h61, CH_CR, CH_CR, CH_LF,
            8'h80, CH_CR, CH_LF,
            8'h31, 8'h32, CH_CR, CH_LF
        };
        rst_n         = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.in_byte = 8'h00;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening[i])
            send_byte(opening[i]);
        drain();

        // The long hold-off lets the result queue fill and push back on the input.
        long_hold <= 1'b1;
        run_phase(0, 0, 160);
        run_phase(64, 0, 290);
        run_phase(0, 64, 420);
        run_phase(24, 24, ITEM_TARGET);

        $display("Sent %0d bytes: directed lines, random messages, broken lines and noise.",
                 bytes_sent);
        $display("Checked %0d tokens under four idling mixes and one long receiver hold-off.",
                 checked);
        if (mismatches == 0 && outstanding == 0)
            $display("[irc_line_tokenizer] OK");
        else
            $display("[irc_line_tokenizer] ERROR");
        $finish;
    end

endmodule

[sim.f]
+incdir+src
src/irc_lt_pkg.sv
src/irc_lt_if.sv
src/irc_lt_step.sv
src/irc_lt_fifo.sv
src/irc_line_tokenizer.sv
test/irc_lt_token_check.sv
test/tb.sv
